// File: rtl/core/rlim_pkg.sv
package rlim_pkg;

	localparam int unsigned RL_NUM_CLASSES = 4;
	localparam int unsigned RL_CLASS_W     = 2;
	localparam int unsigned RL_TIME_W      = 32;
	localparam int unsigned RL_COUNT_W     = 8;
	localparam int unsigned RL_WLEN_W      = 16;
	localparam int unsigned RL_CFG_DATA_W  = 16;

	localparam logic [RL_COUNT_W-1:0] RL_LIMIT_RST = 8'd10;
	localparam logic [RL_WLEN_W-1:0]  RL_WLEN_RST  = 16'd60;

	// register indexes
	localparam logic RL_REG_LIMIT = 1'b0;
	localparam logic RL_REG_WLEN  = 1'b1;

	// item modes
	localparam logic RL_MODE_SUBMIT = 1'b0;
	localparam logic RL_MODE_STATS  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_CALC
	} rl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} rl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} rl_status_t;

endpackage

// File: rtl/core/per_class_fixed_window_rate_limiter_top.sv
// Per-class fixed-window rate limiter.
// The input beat is captured in IDLE; CALC does the class read-modify-write and
// loads the result register once the output is free. A new item is taken only
// after the previous one leaves CALC; a stalled output beat holds the next item in CALC.
// Reset (arst_n low, async): all class windows never opened, counts and note
// flags zero, rate_limit = 10, window_length = 60, no result pending.
module per_class_fixed_window_rate_limiter_top #(
	parameter int unsigned NUM_CLASSES = rlim_pkg::RL_NUM_CLASSES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// event / stats input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 mode,
	input  logic [rlim_pkg::RL_CLASS_W-1:0]      event_class,
	input  logic [rlim_pkg::RL_TIME_W-1:0]       now,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 allowed,
	output logic                                 note,
	output logic [rlim_pkg::RL_COUNT_W-1:0]      count,
	output logic                                 notified,
	// config write channel: index 0 rate_limit, index 1 window_length
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [rlim_pkg::RL_CFG_DATA_W-1:0]   cfg_data
);

	rlim_pkg::rl_cmd_t    cmd;
	rlim_pkg::rl_status_t status;

	// config writes are registered and always accepted
	assign cfg_ready = 1'b1;

	// FSM: IDLE takes an input beat, CALC does the class update and loads
	// the output register once it is free.
	rlim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Class state table, window check, count/note update, result register.
	rlim_dp #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mode        (mode),
		.event_class (event_class),
		.now         (now),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.allowed     (allowed),
		.note        (note),
		.count       (count),
		.notified    (notified)
	);

	// an accepted beat makes the block busy while it is in CALC
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while previous item in calc");

	// allowed and note are exclusive
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(allowed && note))
		else $error("allowed and note both set");

	// a note always leaves the class flag set
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && note) |-> notified)
		else $error("note without notified flag");

	// an allowed event has been counted
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && allowed) |-> (count != '0))
		else $error("allowed event with zero count");

endmodule

// File: rtl/core/rlim_ctrl.sv
module rlim_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rlim_pkg::rl_status_t status,
	output rlim_pkg::rl_cmd_t    cmd
);

	rlim_pkg::rl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlim_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rlim_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = rlim_pkg::ST_CALC;
				end
			end
			rlim_pkg::ST_CALC: begin
				if (!status.out_busy) begin
					state_nxt = rlim_pkg::ST_IDLE;
				end
			end
			default: state_nxt = rlim_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			rlim_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			rlim_pkg::ST_CALC: begin
				cmd.exec = !status.out_busy;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/rlim_dp.sv
module rlim_dp #(
	parameter int unsigned NUM_CLASSES = rlim_pkg::RL_NUM_CLASSES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rlim_pkg::rl_cmd_t                    cmd,
	output rlim_pkg::rl_status_t                 status,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [rlim_pkg::RL_CFG_DATA_W-1:0]   cfg_data,
	input  logic                                 mode,
	input  logic [rlim_pkg::RL_CLASS_W-1:0]      event_class,
	input  logic [rlim_pkg::RL_TIME_W-1:0]       now,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 allowed,
	output logic                                 note,
	output logic [rlim_pkg::RL_COUNT_W-1:0]      count,
	output logic                                 notified
);

	localparam int unsigned IdxW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int unsigned TW   = rlim_pkg::RL_TIME_W;
	localparam int unsigned CW   = rlim_pkg::RL_COUNT_W;
	localparam int unsigned WW   = rlim_pkg::RL_WLEN_W;

	logic [CW-1:0] limit_q;
	logic [WW-1:0] wlen_q;

	logic [TW-1:0] start_q [NUM_CLASSES];
	logic [CW-1:0] cnt_q   [NUM_CLASSES];
	logic          sent_q  [NUM_CLASSES];

	// captured item
	logic                          mode_q;
	logic [rlim_pkg::RL_CLASS_W-1:0] cls_q;
	logic [TW-1:0]                 now_q;

	logic          out_valid_q;
	logic          allowed_q, note_q, notified_q;
	logic [CW-1:0] count_q;

	logic [IdxW-1:0] idx;
	logic            cls_ok;
	logic [TW-1:0]   cur_start, elapsed;
	logic [CW-1:0]   cur_cnt, base_cnt, new_cnt;
	logic            cur_sent, base_sent, new_sent;
	logic            restart, res_allowed, res_note, upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= rlim_pkg::RL_LIMIT_RST;
			wlen_q  <= rlim_pkg::RL_WLEN_RST;
		end else if (cfg_we) begin
			if (cfg_index == rlim_pkg::RL_REG_LIMIT) begin
				limit_q <= cfg_data[CW-1:0];
			end else begin
				wlen_q <= cfg_data[WW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			cls_q  <= event_class;
			now_q  <= now;
		end
	end

	assign idx    = IdxW'(cls_q);
	assign cls_ok = 32'(cls_q) < 32'(NUM_CLASSES);

	always_comb begin
		cur_start   = '0;
		cur_cnt     = '0;
		cur_sent    = 1'b0;
		if (cls_ok) begin
			cur_start = start_q[idx];
			cur_cnt   = cnt_q[idx];
			cur_sent  = sent_q[idx];
		end
		elapsed     = now_q - cur_start;
		restart     = (cur_start == '0) || (elapsed >= TW'(wlen_q));
		base_cnt    = restart ? '0 : cur_cnt;
		base_sent   = restart ? 1'b0 : cur_sent;
		new_cnt     = base_cnt;
		new_sent    = base_sent;
		res_allowed = 1'b0;
		res_note    = 1'b0;
		if (base_cnt < limit_q) begin
			new_cnt     = base_cnt + CW'(1);
			res_allowed = 1'b1;
		end else if (!base_sent) begin
			new_sent = 1'b1;
			res_note = 1'b1;
		end
	end

	assign upd = cmd.exec && cls_ok && (mode_q == rlim_pkg::RL_MODE_SUBMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				start_q[i] <= '0;
				cnt_q[i]   <= '0;
				sent_q[i]  <= 1'b0;
			end
		end else if (upd) begin
			start_q[idx] <= restart ? now_q : cur_start;
			cnt_q[idx]   <= new_cnt;
			sent_q[idx]  <= new_sent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (!cls_ok) begin
				allowed_q  <= 1'b0;
				note_q     <= 1'b0;
				count_q    <= '0;
				notified_q <= 1'b0;
			end else if (mode_q == rlim_pkg::RL_MODE_STATS) begin
				allowed_q  <= 1'b0;
				note_q     <= 1'b0;
				count_q    <= cur_cnt;
				notified_q <= cur_sent;
			end else begin
				allowed_q  <= res_allowed;
				note_q     <= res_note;
				count_q    <= new_cnt;
				notified_q <= new_sent;
			end
		end
	end

	assign status.out_busy = out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign allowed   = allowed_q;
	assign note      = note_q;
	assign count     = count_q;
	assign notified  = notified_q;

endmodule
